// File: rtl/ssm_pkg.sv
// Shared constants, codes and control types of the steering mixer.
package ssm_pkg;

	localparam int SPEED_FRAC_BITS = 8;
	localparam int SPEED_W = 22;
	localparam int AXIS_W = 16;
	localparam int OP_W = 2;
	localparam int GAIN_W = 17;
	localparam int SUM_W = 35;

	localparam logic [OP_W-1:0] OP_PEDAL = 2'd0;
	localparam logic [OP_W-1:0] OP_TILLER = 2'd1;
	localparam logic [OP_W-1:0] OP_SPEED = 2'd2;
	localparam logic [OP_W-1:0] OP_GROUND = 2'd3;

	localparam logic [SPEED_W-1:0] KN20 = SPEED_W'(20 * (1 << SPEED_FRAC_BITS));
	localparam logic [SPEED_W-1:0] KN40 = SPEED_W'(40 * (1 << SPEED_FRAC_BITS));
	localparam logic [SPEED_W-1:0] KN80 = SPEED_W'(80 * (1 << SPEED_FRAC_BITS));
	localparam logic [SPEED_W+1:0] THIRD_KNOT_X3 = (SPEED_W+2)'(1 << SPEED_FRAC_BITS);

	localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd65536;
	localparam logic [GAIN_W-1:0] PEDAL_FLOOR = 17'd5243;
	localparam logic [15:0] PEDAL_SPAN = 16'd60293;

	// tiller: (80kn - s) * 64 / 15, exact via reciprocal for numerators below 2^20
	localparam logic [20:0] TILLER_RECIP = 21'd1118482;
	// pedal: (s - 20kn) * span / 1024 / 5, exact via reciprocal below 2^21 / 3
	localparam logic [18:0] PEDAL_RECIP = 19'd419431;

	localparam logic signed [SUM_W-1:0] SUM_LIM = 35'sd1073741824;
	localparam logic signed [SUM_W-1:0] TRUNC_ADJ = 35'sd65535;

	typedef struct packed {
		logic load;
		logic gain;
		logic sel;
		logic mul;
		logic sum;
	} ssm_cmd_t;

endpackage

// File: rtl/ssm_if.sv
// Valid/ready channel interfaces for demand items and rudder commands.
interface ssm_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         op;
	logic signed [15:0] axis_value;
	logic [21:0]        ground_speed;
	logic               on_ground;

	modport source (output valid, output op, output axis_value, output ground_speed,
		output on_ground, input ready);
	modport sink (input valid, input op, input axis_value, input ground_speed,
		input on_ground, output ready);
endinterface

interface ssm_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] rudder_value;

	modport source (output valid, output rudder_value, input ready);
	modport sink (input valid, input rudder_value, output ready);
endinterface

// File: rtl/ssm_ctrl.sv
// Controller state machine sequencing one item through the mixer datapath.
module ssm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output ssm_pkg::ssm_cmd_t cmd
);
	import ssm_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_GAIN = 3'd1;
	localparam logic [2:0] ST_SEL  = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_SUM  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.load = in_valid && (state_q == ST_IDLE);
		cmd.gain = (state_q == ST_GAIN);
		cmd.sel  = (state_q == ST_SEL);
		cmd.mul  = (state_q == ST_MUL);
		cmd.sum  = (state_q == ST_SUM) && (!out_valid_q || out_ready);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.load) state_d = ST_GAIN;
			end
			ST_GAIN: state_d = ST_SEL;
			ST_SEL:  state_d = ST_MUL;
			ST_MUL:  state_d = ST_SUM;
			ST_SUM: begin
				if (cmd.sum) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.sum) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

// File: rtl/ssm_dp.sv
// Datapath: held demands, speed-scheduled gains, weighted sum and saturation.
module ssm_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ssm_pkg::ssm_cmd_t     cmd,
	input  logic                  cfg_we,
	input  logic                  cfg_wdata,
	input  logic [1:0]            op,
	input  logic signed [15:0]    axis_value,
	input  logic [21:0]           ground_speed,
	input  logic                  on_ground,
	output logic signed [15:0]    rudder_value
);
	import ssm_pkg::*;

	logic                       merge_q;
	logic signed [AXIS_W-1:0]   pedal_q;
	logic signed [AXIS_W-1:0]   tiller_q;
	logic [SPEED_W-1:0]         speed_q;
	logic                       ground_q;

	logic [SPEED_W-1:0]         t_dist_w;
	logic [SPEED_W-1:0]         p_dist_w;
	logic [40:0]                t_prod;
	logic [28:0]                p_prod;
	logic [37:0]                p_quot;
	logic [SPEED_W+1:0]         speed_x3;

	logic [GAIN_W-1:0]          tq_s1;
	logic [18:0]                pprod_s1;
	logic                       sched_s1;
	logic                       fast_s1;
	logic                       t_hi_s1;
	logic                       lo_s1;
	logic                       p_hi_s1;

	logic [GAIN_W-1:0]          gp_s2;
	logic [GAIN_W-1:0]          gt_s2;

	logic signed [33:0]         pp_s3;
	logic signed [33:0]         tp_s3;

	logic signed [SUM_W-1:0]    sum_w;
	logic signed [SUM_W-1:0]    clamp_w;
	logic signed [SUM_W-1:0]    adj_w;
	logic signed [SUM_W-1:0]    shr_w;
	logic signed [15:0]         rudder_q;

	assign t_dist_w = KN80 - speed_q;
	assign p_dist_w = speed_q - KN20;
	assign t_prod   = 41'({t_dist_w[13:0], 6'b0}) * 41'(TILLER_RECIP);
	assign p_prod   = 29'(p_dist_w[12:0]) * 29'(PEDAL_SPAN);
	assign p_quot   = 38'(pprod_s1) * 38'(PEDAL_RECIP);
	assign speed_x3 = (SPEED_W+2)'(speed_q) + (SPEED_W+2)'({speed_q, 1'b0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			merge_q  <= 1'b0;
			pedal_q  <= '0;
			tiller_q <= '0;
			speed_q  <= '0;
			ground_q <= 1'b0;
		end else begin
			if (cfg_we) merge_q <= cfg_wdata;
			if (cmd.load) begin
				case (op)
					OP_PEDAL:  pedal_q  <= axis_value;
					OP_TILLER: tiller_q <= axis_value;
					OP_SPEED:  speed_q  <= ground_speed;
					OP_GROUND: ground_q <= on_ground;
					default:   ground_q <= on_ground;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.gain) begin
			tq_s1    <= t_prod[40:24];
			pprod_s1 <= p_prod[28:10];
			sched_s1 <= merge_q && ground_q;
			fast_s1  <= (speed_x3 > THIRD_KNOT_X3);
			t_hi_s1  <= (speed_q >= KN80);
			lo_s1    <= (speed_q <= KN20);
			p_hi_s1  <= (speed_q >= KN40);
		end
		if (cmd.sel) begin
			if (!sched_s1 || !fast_s1 || p_hi_s1) begin
				gp_s2 <= GAIN_ONE;
			end else if (lo_s1) begin
				gp_s2 <= PEDAL_FLOOR;
			end else begin
				gp_s2 <= PEDAL_FLOOR + p_quot[37:21];
			end
			if (!sched_s1 || t_hi_s1) begin
				gt_s2 <= '0;
			end else if (lo_s1) begin
				gt_s2 <= GAIN_ONE;
			end else begin
				gt_s2 <= tq_s1;
			end
		end
		if (cmd.mul) begin
			pp_s3 <= 34'(pedal_q) * 34'($signed({1'b0, gp_s2}));
			tp_s3 <= 34'(tiller_q) * 34'($signed({1'b0, gt_s2}));
		end
		if (cmd.sum) rudder_q <= shr_w[15:0];
	end

	always_comb begin
		sum_w = SUM_W'(pp_s3) + SUM_W'(tp_s3);
		if (sum_w > SUM_LIM) begin
			clamp_w = SUM_LIM;
		end else if (sum_w < -SUM_LIM) begin
			clamp_w = -SUM_LIM;
		end else begin
			clamp_w = sum_w;
		end
		adj_w = clamp_w[SUM_W-1] ? clamp_w + TRUNC_ADJ : clamp_w;
		shr_w = adj_w >>> 16;
	end

	assign rudder_value = rudder_q;
endmodule

// File: rtl/speed_scheduled_steering_mixer_unit.sv
// Sequencing: each accepted item steps through the gain, select, multiply and
// sum states of the shared datapath before a new input transfer is taken; the
// sum step waits while an earlier result is not taken, but a result waiting in
// the output register does not block the next input transfer.
// Reset: arst_n clears demands, speed, ground flag and merge flag to zero.
module speed_scheduled_steering_mixer_unit (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	ssm_in_if.sink    demand,
	ssm_out_if.source command
);
	import ssm_pkg::*;

	ssm_cmd_t cmd;

	ssm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (demand.valid),
		.in_ready  (demand.ready),
		.out_valid (command.valid),
		.out_ready (command.ready),
		.cmd       (cmd)
	);

	ssm_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.op           (demand.op),
		.axis_value   (demand.axis_value),
		.ground_speed (demand.ground_speed),
		.on_ground    (demand.on_ground),
		.rudder_value (command.rudder_value)
	);
endmodule

// File: tb/speed_scheduled_steering_mixer_unit_test.sv
// Self-checking test of the steering mixer: directed script and random demand updates.
module speed_scheduled_steering_mixer_unit_test;
	import ssm_pkg::*;

	localparam longint KNOT = longint'(1) << SPEED_FRAC_BITS;
	localparam longint UNITY_GAIN = 65536;
	localparam longint PEDAL_MIN_GAIN = 5243;
	localparam longint RUDDER_FULL = 16384;
	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS = 200;
	localparam int HOLD_OFF_AT = 400;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int SCRIPT_LEN = 25;

	typedef struct packed {
		logic               merge;
		logic [OP_W-1:0]    op;
		logic signed [15:0] axis;
		logic [21:0]        speed;
		logic               gnd;
		logic               typed;
		logic signed [15:0] rudder;
	} steer_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	ssm_in_if  demand_ch ();
	ssm_out_if command_ch ();

	speed_scheduled_steering_mixer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.demand    (demand_ch),
		.command   (command_ch)
	);

	always #5 clk = ~clk;

	logic               merge_setting;
	logic signed [15:0] pedal_held;
	logic signed [15:0] tiller_held;
	logic [21:0]        speed_held;
	logic               ground_held;
	logic signed [15:0] rudder_due_q[$];

	int mismatches = 0;
	int items_sent = 0;
	int results_seen = 0;
	int recv_hold = 0;
	int stalled_cycles = 0;
	bit sender_fast = 1'b0;
	bit receiver_fast = 1'b0;

	steer_row_t script [SCRIPT_LEN] = '{
		'{1'b0, OP_PEDAL,  16'sd16384,   22'd0,        1'b0, 1'b1, 16'sd16384},
		'{1'b0, OP_PEDAL,  -16'sd16384,  22'd0,        1'b0, 1'b1, -16'sd16384},
		'{1'b0, OP_PEDAL,  16'sd32767,   22'd0,        1'b0, 1'b1, 16'sd16384},
		'{1'b0, OP_PEDAL,  16'sh8000,    22'd0,        1'b0, 1'b1, -16'sd16384},
		'{1'b0, OP_TILLER, 16'sd12345,   22'h155555,   1'b1, 1'b1, -16'sd16384},
		'{1'b0, OP_GROUND, 16'sh7abc,    22'h2aaaaa,   1'b1, 1'b1, -16'sd16384},
		'{1'b0, OP_SPEED,  -16'sd1,      22'h3fffff,   1'b0, 1'b1, -16'sd16384},
		'{1'b1, OP_PEDAL,  16'sd1000,    22'd0,        1'b0, 1'b1, 16'sd1000},
		'{1'b1, OP_SPEED,  16'sh5555,    22'd0,        1'b0, 1'b1, 16'sd13345},
		'{1'b1, OP_SPEED,  16'sd0,       22'd85,       1'b0, 1'b0, 16'sd0},
		'{1'b1, OP_SPEED,  16'sd0,       22'd86,       1'b0, 1'b0, 16'sd0},
		'{1'b1, OP_SPEED,  16'sd0,       22'd5120,     1'b0, 1'b0, 16'sd0},
		'{1'b1, OP_SPEED,  16'sd0,       22'd5121,     1'b0, 1'b0, 16'sd0},
		'{1'b1, OP_SPEED,  16'sd0,       22'd10239,    1'b0, 1'b0, 16'sd0},
		'{1'b1, OP_SPEED,  16'sd0,       22'd10240,    1'b0, 1'b0, 16'sd0},
		'{1'b1, OP_SPEED,  16'sd0,       22'd20479,    1'b0, 1'b0, 16'sd0},
		'{1'b1, OP_SPEED,  16'sd0,       22'd20480,    1'b0, 1'b0, 16'sd0},
		'{1'b1, OP_TILLER, 16'sd32767,   22'd0,        1'b0, 1'b0, 16'sd0},
		'{1'b1, OP_SPEED,  16'sd0,       22'd5120,     1'b0, 1'b0, 16'sd0},
		'{1'b1, OP_TILLER, 16'sh8000,    22'd0,        1'b0, 1'b0, 16'sd0},
		'{1'b1, OP_PEDAL,  16'sh8000,    22'd0,        1'b0, 1'b0, 16'sd0},
		'{1'b1, OP_GROUND, 16'sd0,       22'd0,        1'b0, 1'b0, 16'sd0},
		'{1'b1, OP_GROUND, 16'sd0,       22'd0,        1'b1, 1'b0, 16'sd0},
		'{1'b1, OP_SPEED,  16'sd0,       22'd15000,    1'b0, 1'b0, 16'sd0},
		'{1'b1, OP_SPEED,  16'sd0,       22'h3fffff,   1'b0, 1'b0, 16'sd0}
	};

	function automatic logic signed [15:0] rudder_for(input logic merge, input logic gnd,
		input logic signed [15:0] pedal, input logic signed [15:0] tiller,
		input logic [21:0] spd);
		longint s;
		longint tiller_gain;
		longint pedal_gain;
		longint total;
		s = longint'(spd);
		tiller_gain = 0;
		pedal_gain = UNITY_GAIN;
		if (merge && gnd) begin
			if (s >= 80 * KNOT)
				tiller_gain = 0;
			else if (s <= 20 * KNOT)
				tiller_gain = UNITY_GAIN;
			else
				tiller_gain = ((80 * KNOT - s) * UNITY_GAIN) / (60 * KNOT);
			if (3 * s > KNOT) begin
				if (s >= 40 * KNOT)
					pedal_gain = UNITY_GAIN;
				else if (s <= 20 * KNOT)
					pedal_gain = PEDAL_MIN_GAIN;
				else
					pedal_gain = PEDAL_MIN_GAIN
						+ ((s - 20 * KNOT) * (UNITY_GAIN - PEDAL_MIN_GAIN)) / (20 * KNOT);
			end
		end
		total = longint'(pedal) * pedal_gain + longint'(tiller) * tiller_gain;
		if (total > RUDDER_FULL * UNITY_GAIN)
			total = RUDDER_FULL * UNITY_GAIN;
		if (total < -RUDDER_FULL * UNITY_GAIN)
			total = -RUDDER_FULL * UNITY_GAIN;
		return 16'(total / UNITY_GAIN);
	endfunction

	function automatic int draw_gap(input bit fast);
		return fast ? 0 : $urandom_range(0, 15);
	endfunction

	task automatic send_item(input logic [OP_W-1:0] op, input logic signed [15:0] axis,
		input logic [21:0] spd, input logic gnd, input logic typed,
		input logic signed [15:0] typed_rudder);
		int gap;
		if (items_sent % 40 == 0)
			sender_fast = ($urandom_range(0, 2) == 0);
		gap = draw_gap(sender_fast);
		@(negedge clk);
		if (gap > 0) begin
			demand_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		demand_ch.valid <= 1'b1;
		demand_ch.op <= op;
		demand_ch.axis_value <= axis;
		demand_ch.ground_speed <= spd;
		demand_ch.on_ground <= gnd;
		@(posedge clk);
		while (!demand_ch.ready)
			@(posedge clk);
		case (op)
			OP_PEDAL:  pedal_held = axis;
			OP_TILLER: tiller_held = axis;
			OP_SPEED:  speed_held = spd;
			default:   ground_held = gnd;
		endcase
		rudder_due_q.push_back(typed ? typed_rudder
			: rudder_for(merge_setting, ground_held, pedal_held, tiller_held, speed_held));
		items_sent++;
	endtask

	task automatic program_merge(input logic value);
		@(negedge clk);
		demand_ch.valid <= 1'b0;
		while (rudder_due_q.size() != 0)
			@(posedge clk);
		repeat (8) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		merge_setting = value;
	endtask

	// receiver: hold ready low while a stall is pending
	initial begin
		command_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (recv_hold > 0) begin
				command_ch.ready <= 1'b0;
				recv_hold--;
			end else begin
				command_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		logic signed [15:0] due;
		if (command_ch.valid && command_ch.ready) begin
			if (rudder_due_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected rudder transfer: got %0d", command_ch.rudder_value);
			end else begin
				due = rudder_due_q.pop_front();
				if (command_ch.rudder_value !== due) begin
					mismatches++;
					if (mismatches <= 10)
						$display("rudder_value mismatch at result %0d: expected %0d, got %0d",
							results_seen, due, command_ch.rudder_value);
				end
			end
			results_seen++;
			if (results_seen % 40 == 0)
				receiver_fast = ($urandom_range(0, 2) == 0);
			if (results_seen == HOLD_OFF_AT)
				recv_hold = HOLD_OFF_CYCLES;
			else
				recv_hold = draw_gap(receiver_fast);
		end
	end

	always @(posedge clk) begin
		if ((demand_ch.valid && demand_ch.ready) || (command_ch.valid && command_ch.ready)) begin
			stalled_cycles = 0;
		end else begin
			stalled_cycles++;
			if (stalled_cycles == STALL_LIMIT) begin
				$display("speed_scheduled_steering_mixer_unit_test: FAIL");
				$finish;
			end
		end
	end

	initial begin
		logic [OP_W-1:0]    op;
		logic signed [15:0] axis;
		logic [21:0]        spd;
		logic               gnd;
		int                 base;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		demand_ch.valid = 1'b0;
		demand_ch.op = OP_PEDAL;
		demand_ch.axis_value = '0;
		demand_ch.ground_speed = '0;
		demand_ch.on_ground = 1'b0;
		merge_setting = 1'b0;
		pedal_held = '0;
		tiller_held = '0;
		speed_held = '0;
		ground_held = 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < SCRIPT_LEN; i++) begin
			if (script[i].merge != merge_setting)
				program_merge(script[i].merge);
			send_item(script[i].op, script[i].axis, script[i].speed, script[i].gnd,
				script[i].typed, script[i].rudder);
		end

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			program_merge(phase % 2 == 0 ? 1'b0 : 1'b1);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				op = OP_W'($urandom_range(0, 3));
				case ($urandom_range(0, 7))
					0: axis = 16'($urandom);
					1: begin
						case ($urandom_range(0, 4))
							0: axis = 16'sd16384;
							1: axis = -16'sd16384;
							2: axis = 16'sd32767;
							3: axis = 16'sh8000;
							default: axis = 16'sd0;
						endcase
					end
					default: axis = 16'(int'($urandom_range(0, 32768)) - 16384);
				endcase
				case ($urandom_range(0, 9))
					6: begin
						case ($urandom_range(0, 3))
							0: base = 86;
							1: base = 5120;
							2: base = 10240;
							default: base = 20480;
						endcase
						spd = 22'(base + int'($urandom_range(0, 4)) - 2);
					end
					7, 8: spd = 22'($urandom_range(0, 300));
					9: spd = 22'($urandom);
					default: spd = 22'($urandom_range(0, 21000));
				endcase
				gnd = ($urandom_range(0, 3) != 0);
				send_item(op, axis, spd, gnd, 1'b0, 16'sd0);
			end
		end

		@(negedge clk);
		demand_ch.valid <= 1'b0;
		while (rudder_due_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("speed_scheduled_steering_mixer_unit_test: PASS");
		else
			$display("speed_scheduled_steering_mixer_unit_test: FAIL");
		$finish;
	end

endmodule
